/* src/slpf_pkg.sv */
// ----------------------------------------------------------------------------
// slpf_pkg: shared types and constants of the sync/length packet framer
// Ring geometry, register indexes, reset values and the command record that
// the parser hands to the emitter.
// ----------------------------------------------------------------------------
package slpf_pkg;

    localparam int RING_AW    = 7;
    localparam int RING_DEPTH = 1 << RING_AW;
    localparam int PTR_W      = RING_AW + 1;
    localparam int LEN_W      = 7;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_LEN    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHK_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHK_HI = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'h53;
    localparam logic [BYTE_W-1:0] CHK_LO_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] CHK_HI_RESET = 8'hEB;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef struct packed {
        t_ptr             start;
        logic [LEN_W-1:0] len;
    } t_cmd;

endpackage

/* src/slpf_if.sv */
// ----------------------------------------------------------------------------
// slpf_if: channel interfaces of the packet framer
// Received byte stream, framed output stream and the register write channel.
// ----------------------------------------------------------------------------
interface slpf_in_if import slpf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface slpf_out_if import slpf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

interface slpf_cfg_if import slpf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/sync_length_packet_framer_top.sv */
// ----------------------------------------------------------------------------
// sync_length_packet_framer_top: sync/length packet framer
// Hunts for a sync byte, frames by the declared length, checks the two final
// bytes and forwards good packets; failed packets are rescanned for a sync.
//
//   channel   dir   payload               handshake
//   i_in      in    in_byte[7:0]          valid/ready
//   o_out     out   out_byte[7:0], last   valid/ready
//   i_cfg     in    index[1:0], data[7:0] valid/ready (always ready)
//
// Each received byte passes through the parser's ring read and then its execute step.
// A failed check rescans the buffered bytes of the packet, one read and compare each.
// Each output beat is read from the ring, then held until taken before the next read.
// The 128-byte ring needs no clearing; reset only clears pointers and state.
// Input stalls only when the ring is full of bytes not yet framed or emitted.
// ----------------------------------------------------------------------------
module sync_length_packet_framer_top
    import slpf_pkg::*;
#(
    parameter int MAX_PACKET = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slpf_in_if.sink     i_in,
    slpf_out_if.source  o_out,
    slpf_cfg_if.sink    i_cfg
);

    logic [BYTE_W-1:0] r_sync;
    logic [BYTE_W-1:0] r_chk_lo;
    logic [BYTE_W-1:0] r_chk_hi;
    t_ptr              r_tail;

    t_ptr              p_rd_ptr;
    t_ptr              p_head;
    logic              p_push;
    t_cmd              p_cmd;
    logic [BYTE_W-1:0] p_rd_data;
    logic              q_push_ready;
    logic              q_valid;
    t_cmd              q_cmd;
    logic              e_pop;
    t_ptr              e_rd_ptr;
    logic [BYTE_W-1:0] e_rd_data;
    logic              e_busy;
    t_ptr              e_cur_ptr;

    t_ptr              n_oldest;
    t_ptr              n_used;
    logic              n_in_acc;

    // The oldest byte still needed, in stream order: emitter, queue, parser.
    always_comb begin
        if (e_busy) begin
            n_oldest = e_cur_ptr;
        end else if (q_valid) begin
            n_oldest = q_cmd.start;
        end else begin
            n_oldest = p_head;
        end
        n_used = t_ptr'(r_tail - n_oldest);
    end

    assign i_in.ready  = !n_used[PTR_W-1];
    assign n_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync   <= SYNC_RESET;
            r_chk_lo <= CHK_LO_RESET;
            r_chk_hi <= CHK_HI_RESET;
            r_tail   <= '0;
        end else begin
            if (n_in_acc) begin
                r_tail <= t_ptr'(r_tail + 1'b1);
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_SYNC:   r_sync   <= i_cfg.data;
                    CFG_CHK_LO: r_chk_lo <= i_cfg.data;
                    CFG_CHK_HI: r_chk_hi <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    slpf_ring u_ring (
        .i_clk       (i_clk),
        .i_wr_en     (n_in_acc),
        .i_wr_ptr    (r_tail),
        .i_wr_data   (i_in.in_byte),
        .i_rd_a_ptr  (p_rd_ptr),
        .i_rd_b_ptr  (e_rd_ptr),
        .o_rd_a_data (p_rd_data),
        .o_rd_b_data (e_rd_data)
    );

    slpf_parse #(
        .MAX_PACKET (MAX_PACKET)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sync       (r_sync),
        .i_chk_lo     (r_chk_lo),
        .i_chk_hi     (r_chk_hi),
        .i_tail       (r_tail),
        .i_rd_data    (p_rd_data),
        .o_rd_ptr     (p_rd_ptr),
        .o_head       (p_head),
        .o_push       (p_push),
        .o_cmd        (p_cmd),
        .i_push_ready (q_push_ready)
    );

    slpf_cmdq u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (p_push),
        .i_cmd        (p_cmd),
        .o_push_ready (q_push_ready),
        .o_valid      (q_valid),
        .o_cmd        (q_cmd),
        .i_pop        (e_pop)
    );

    slpf_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (e_pop),
        .o_rd_ptr    (e_rd_ptr),
        .i_rd_data   (e_rd_data),
        .o_busy      (e_busy),
        .o_cur_ptr   (e_cur_ptr),
        .o_valid     (o_out.valid),
        .o_byte      (o_out.out_byte),
        .o_last      (o_out.last),
        .i_ready     (o_out.ready)
    );

endmodule

/* src/slpf_ring.sv */
// ----------------------------------------------------------------------------
// slpf_ring: byte ring buffer
// One write port and two registered read ports over the received stream.
// ----------------------------------------------------------------------------
module slpf_ring
    import slpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  t_ptr              i_wr_ptr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  t_ptr              i_rd_a_ptr,
    input  t_ptr              i_rd_b_ptr,
    output logic [BYTE_W-1:0] o_rd_a_data,
    output logic [BYTE_W-1:0] o_rd_b_data
);

    logic [BYTE_W-1:0] r_mem [RING_DEPTH];
    logic [BYTE_W-1:0] r_rd_a;
    logic [BYTE_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_ptr[RING_AW-1:0]] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_a_ptr[RING_AW-1:0]];
        r_rd_b <= r_mem[i_rd_b_ptr[RING_AW-1:0]];
    end

    assign o_rd_a_data = r_rd_a;
    assign o_rd_b_data = r_rd_b;

endmodule

/* src/slpf_parse.sv */
// ----------------------------------------------------------------------------
// slpf_parse: framing front end
// Walks the buffered stream, tracks the packet phase, checks length and check
// bytes, and queues accepted packets or rescans a failed one for a new sync.
// ----------------------------------------------------------------------------
module slpf_parse
    import slpf_pkg::*;
#(
    parameter int MAX_PACKET = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BYTE_W-1:0] i_sync,
    input  logic [BYTE_W-1:0] i_chk_lo,
    input  logic [BYTE_W-1:0] i_chk_hi,
    input  t_ptr              i_tail,
    input  logic [BYTE_W-1:0] i_rd_data,
    output t_ptr              o_rd_ptr,
    output t_ptr              o_head,
    output logic              o_push,
    output t_cmd              o_cmd,
    input  logic              i_push_ready
);

    typedef enum logic [2:0] {S_FETCH, S_EXEC, S_PUSH, S_SRD, S_SCHK} t_state;
    typedef enum logic [2:0] {PH_HUNT, PH_ADDR, PH_LEN_LO, PH_LEN_HI, PH_BODY} t_phase;

    t_state            r_state;
    t_phase            r_phase;
    t_ptr              r_head;
    t_ptr              r_proc;
    t_ptr              r_srch;
    logic [BYTE_W-1:0] r_len_lo;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_prev;
    t_cmd              r_cmd;

    t_ptr              n_proc;
    t_ptr              n_count;
    logic [15:0]       n_len16;
    logic              n_bad_len;

    always_comb begin
        n_proc    = t_ptr'(r_proc + 1'b1);
        n_count   = t_ptr'(n_proc - r_head);
        n_len16   = {i_rd_data, r_len_lo};
        n_bad_len = (n_len16 < 16'(MIN_LEN)) || (n_len16 > 16'(MAX_PACKET));
    end

    assign o_rd_ptr = (r_state == S_SRD) ? r_srch : r_proc;
    assign o_head   = r_head;
    assign o_push   = (r_state == S_PUSH);
    assign o_cmd    = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FETCH;
            r_phase <= PH_HUNT;
            r_head  <= '0;
            r_proc  <= '0;
        end else begin
            unique case (r_state)
                S_FETCH: begin
                    if (r_proc != i_tail) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_proc  <= n_proc;
                    r_prev  <= i_rd_data;
                    r_state <= S_FETCH;
                    unique case (r_phase)
                        PH_HUNT: begin
                            if (i_rd_data == i_sync) begin
                                r_head  <= r_proc;
                                r_phase <= PH_ADDR;
                            end else begin
                                r_head <= n_proc;
                            end
                        end
                        PH_ADDR: r_phase <= PH_LEN_LO;
                        PH_LEN_LO: begin
                            r_len_lo <= i_rd_data;
                            r_phase  <= PH_LEN_HI;
                        end
                        PH_LEN_HI: begin
                            if (n_bad_len) begin
                                r_srch  <= t_ptr'(r_head + 1'b1);
                                r_phase <= PH_HUNT;
                                r_state <= S_SRD;
                            end else begin
                                r_len   <= LEN_W'(n_len16);
                                r_phase <= PH_BODY;
                            end
                        end
                        PH_BODY: begin
                            if (n_count >= PTR_W'(r_len)) begin
                                r_phase <= PH_HUNT;
                                if (r_prev == i_chk_lo && i_rd_data == i_chk_hi) begin
                                    r_cmd.start <= r_head;
                                    r_cmd.len   <= LEN_W'(n_count);
                                    r_state     <= S_PUSH;
                                end else begin
                                    r_srch  <= t_ptr'(r_head + 1'b1);
                                    r_state <= S_SRD;
                                end
                            end
                        end
                        default: r_phase <= PH_HUNT;
                    endcase
                end
                S_PUSH: begin
                    // The head holds the packet until the command queue takes it.
                    if (i_push_ready) begin
                        r_head  <= r_proc;
                        r_state <= S_FETCH;
                    end
                end
                S_SRD: begin
                    if (r_srch == r_proc) begin
                        r_head  <= r_proc;
                        r_state <= S_FETCH;
                    end else begin
                        r_state <= S_SCHK;
                    end
                end
                S_SCHK: begin
                    // A sync inside the failed packet restarts framing there.
                    if (i_rd_data == i_sync) begin
                        r_head  <= r_srch;
                        r_proc  <= r_srch;
                        r_state <= S_FETCH;
                    end else begin
                        r_srch  <= t_ptr'(r_srch + 1'b1);
                        r_state <= S_SRD;
                    end
                end
                default: r_state <= S_FETCH;
            endcase
        end
    end

endmodule

/* src/slpf_cmdq.sv */
// ----------------------------------------------------------------------------
// slpf_cmdq: packet command queue
// Two-entry queue of accepted packet ranges between parser and emitter.
// ----------------------------------------------------------------------------
module slpf_cmdq
    import slpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_push_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd       r_ent [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic n_do_push;
    logic n_do_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_valid      = (r_cnt != 2'd0);
    assign o_cmd        = r_ent[r_rd];
    assign n_do_push    = i_push && o_push_ready;
    assign n_do_pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_do_push) begin
                r_ent[r_wr] <= i_cmd;
                r_wr        <= !r_wr;
            end
            if (n_do_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= 2'(r_cnt + {1'b0, n_do_push} - {1'b0, n_do_pop});
        end
    end

endmodule

/* src/slpf_emit.sv */
// ----------------------------------------------------------------------------
// slpf_emit: packet emitter back end
// Reads each queued packet out of the ring and presents it beat by beat.
// ----------------------------------------------------------------------------
module slpf_emit
    import slpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output t_ptr              o_rd_ptr,
    input  logic [BYTE_W-1:0] i_rd_data,
    output logic              o_busy,
    output t_ptr              o_cur_ptr,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_last,
    input  logic              i_ready
);

    typedef enum logic [1:0] {E_IDLE, E_LOAD, E_HOLD} t_state;

    t_state            r_state;
    t_ptr              r_ptr;
    logic [LEN_W-1:0]  r_rem;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    always_comb begin
        case (r_state)
            E_IDLE:  o_rd_ptr = i_cmd.start;
            E_HOLD:  o_rd_ptr = t_ptr'(r_ptr + 1'b1);
            default: o_rd_ptr = r_ptr;
        endcase
    end

    assign o_cmd_pop = (r_state == E_IDLE) && i_cmd_valid;
    assign o_busy    = (r_state != E_IDLE);
    assign o_cur_ptr = r_ptr;
    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                E_IDLE: begin
                    if (i_cmd_valid) begin
                        r_ptr   <= i_cmd.start;
                        r_rem   <= i_cmd.len;
                        r_state <= E_LOAD;
                    end
                end
                E_LOAD: begin
                    r_byte  <= i_rd_data;
                    r_last  <= (r_rem == LEN_W'(1));
                    r_valid <= 1'b1;
                    r_state <= E_HOLD;
                end
                E_HOLD: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        if (r_rem == LEN_W'(1)) begin
                            r_state <= E_IDLE;
                        end else begin
                            r_ptr   <= t_ptr'(r_ptr + 1'b1);
                            r_rem   <= LEN_W'(r_rem - 1'b1);
                            r_state <= E_LOAD;
                        end
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

endmodule

/* src/slpf_checker.sv */
// ----------------------------------------------------------------------------
// slpf_checker: port-level checks of the packet framer
// Output handshake rules, reset behavior and minimum packet length.
// ----------------------------------------------------------------------------
module slpf_checker
    import slpf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] i_out_byte,
    input logic              i_out_last
);

    // Beats seen since the last end of packet, saturating.
    logic [2:0] r_beats;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beats <= 3'd0;
        end else if (i_out_valid && i_out_ready) begin
            if (i_out_last) begin
                r_beats <= 3'd0;
            end else if (r_beats != 3'd7) begin
                r_beats <= 3'(r_beats + 1'b1);
            end
        end
    end

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat withdrawn while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output payload changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output beat right after reset");

    a_min_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |-> r_beats >= 3'(MIN_LEN - 1))
        else $error("packet shorter than the minimum length");

endmodule

bind sync_length_packet_framer_top slpf_checker u_slpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the sync/length packet framer
// Drives received bytes with random gaps, predicts framed output beats with
// an internal framer model and compares every output beat in order.
// ----------------------------------------------------------------------------
module testbench;
    import slpf_pkg::*;

    localparam int PKT_MAX = 64;
    localparam int CYCLE_LIMIT = 1500000;

    typedef enum logic [2:0] {
        HUNT, ADDR, LEN_LO, LEN_HI, BODY
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_beat;

    logic i_clk;
    logic i_rst_n;

    slpf_in_if  in_ch ();
    slpf_out_if out_ch ();
    slpf_cfg_if cfg_ch ();

    sync_length_packet_framer_top #(.MAX_PACKET(PKT_MAX)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // Framer model state.
    logic [7:0]  sync_byte;
    logic [7:0]  chk_lo;
    logic [7:0]  chk_hi;
    t_phase      phase;
    logic [15:0] decl_len;
    int          fill;
    logic [7:0]  frame_buf [PKT_MAX];
    logic [7:0]  pending [$];

    t_beat       expected_beats [$];
    int          error_count;
    int          cycle_count;
    int          hold_off_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    // Failed check: rescan from the next sync after the start, ahead of any
    // bytes still waiting in this step.
    task automatic reject_frame();
        int s;
        logic [7:0] tail [$];
        s = 0;
        for (int i = 1; i < fill; i++) begin
            if (frame_buf[i] == sync_byte) begin
                s = i;
                break;
            end
        end
        if (s != 0) begin
            for (int i = s; i < fill; i++) tail.insert(tail.size(), frame_buf[i]);
        end
        pending = {tail, pending};
        phase = HUNT;
        fill = 0;
        decl_len = 0;
    endtask

    task automatic frame_byte(input logic [7:0] b);
        case (phase)
            HUNT: begin
                if (b == sync_byte) begin
                    fill = 1;
                    frame_buf[0] = b;
                    decl_len = 0;
                    phase = ADDR;
                end
            end
            ADDR: begin
                frame_buf[fill] = b;
                fill++;
                phase = LEN_LO;
            end
            LEN_LO: begin
                frame_buf[fill] = b;
                fill++;
                decl_len = {8'h00, b};
                phase = LEN_HI;
            end
            LEN_HI: begin
                frame_buf[fill] = b;
                fill++;
                decl_len[15:8] = b;
                if (decl_len < 6 || decl_len > PKT_MAX) reject_frame();
                else phase = BODY;
            end
            default: begin
                if (fill < PKT_MAX) begin
                    frame_buf[fill] = b;
                    fill++;
                end
                if (fill >= decl_len) begin
                    if (frame_buf[fill-2] == chk_lo && frame_buf[fill-1] == chk_hi) begin
                        for (int i = 0; i < fill; i++)
                            expected_beats.insert(expected_beats.size(),
                                                  {frame_buf[i], 1'(i == fill - 1)});
                        phase = HUNT;
                        fill = 0;
                        decl_len = 0;
                    end else begin
                        reject_frame();
                    end
                end
            end
        endcase
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [7:0] nb;
        pending.insert(pending.size(), b);
        while (pending.size() > 0) begin
            nb = pending[0];
            pending.delete(0);
            frame_byte(nb);
        end
    endtask

    function automatic int random_gap();
        if ($urandom_range(9) < 5) return 0;
        if ($urandom_range(19) == 0) return $urandom_range(60, 20);
        return $urandom_range(3);
    endfunction

    // Valid stays high after the beat; the next send or a drain takes it down.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = random_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_byte(b);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_SYNC:   sync_byte = v;
            CFG_CHK_LO: chk_lo = v;
            CFG_CHK_HI: chk_hi = v;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_beats.size() > 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    // Whole packet of given total length with matching or broken check bytes.
    task automatic send_frame(input int len, input bit good);
        send_byte(sync_byte);
        send_byte(8'($urandom));
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (int i = 4; i < len - 2; i++) send_byte(8'($urandom));
        send_byte(good ? chk_lo : 8'($urandom));
        send_byte(good ? chk_hi : 8'($urandom));
    endtask

    task automatic test_directed();
        send_frame(6, 1);
        send_frame(6, 0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sync_byte);
        send_byte(8'h01);
        send_byte(8'h05);
        send_byte(8'h00);
        send_byte(sync_byte);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h01);
        send_frame(7, 1);
        drain();
    endtask

    // A failing frame that carries two complete good frames inside its body.
    task automatic test_resync();
        send_byte(sync_byte);
        send_byte(8'h11);
        send_byte(8'd20);
        send_byte(8'h00);
        send_frame(8, 1);
        send_frame(6, 1);
        drain();
    endtask

    task automatic test_random(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(9))
                0: begin
                    send_byte(8'($urandom));
                    sent++;
                end
                1: begin
                    send_byte(sync_byte);
                    send_byte(8'($urandom));
                    send_byte(8'($urandom));
                    send_byte($urandom_range(1) ? 8'h00 : 8'($urandom));
                    sent += 4;
                end
                2, 3: begin
                    send_frame($urandom_range(12, 6), 0);
                    sent += 8;
                end
                default: begin
                    send_frame(($urandom_range(7) == 0) ? $urandom_range(PKT_MAX, 6)
                                                        : $urandom_range(12, 6), 1);
                    sent += 8;
                end
            endcase
        end
        drain();
    endtask

    // Three packets that together outgrow the buffer while the output is held.
    task automatic test_backpressure();
        hold_off_cycles = 1000;
        send_frame(PKT_MAX, 1);
        send_frame(40, 1);
        send_frame(30, 1);
        drain();
    endtask

    task automatic test_registers();
        write_reg(CFG_SYNC, 8'h00);
        write_reg(CFG_CHK_LO, 8'h00);
        write_reg(CFG_CHK_HI, 8'h00);
        test_random(8);
        write_reg(CFG_SYNC, 8'hFF);
        write_reg(CFG_CHK_LO, 8'hFF);
        write_reg(CFG_CHK_HI, 8'hFF);
        test_random(8);
        write_reg(CFG_SYNC, 8'($urandom));
        write_reg(CFG_CHK_LO, 8'($urandom));
        write_reg(CFG_CHK_HI, 8'($urandom));
        test_random(8);
    endtask

    // Output receiver with random stalls and one long requested hold-off.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                out_ch.ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                out_ch.ready <= ($urandom_range(9) < 6) || (cycle_count % 3000 < 800);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat", out_ch.out_byte, 0);
            end else begin
                t_beat want;
                want = expected_beats[0];
                expected_beats.delete(0);
                if (out_ch.out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
                if (out_ch.last !== want.last)
                    report_mismatch("last", out_ch.last, want.last);
            end
        end
    end

    initial begin
        error_count     = 0;
        cycle_count     = 0;
        hold_off_cycles = 0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.in_byte   = 8'h00;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_SYNC;
        cfg_ch.data     = 8'h00;
        sync_byte       = SYNC_RESET;
        chk_lo          = CHK_LO_RESET;
        chk_hi          = CHK_HI_RESET;
        phase           = HUNT;
        decl_len        = 0;
        fill            = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_resync();
        test_backpressure();
        test_random(20);
        test_registers();
        if (error_count == 0) $display("testbench: clean");
        else $display("testbench: errors");
        $finish;
    end

endmodule

/* sync_length_packet_framer_top.f */
src/slpf_pkg.sv
src/slpf_if.sv
src/slpf_ring.sv
src/slpf_parse.sv
src/slpf_cmdq.sv
src/slpf_emit.sv
src/sync_length_packet_framer_top.sv
src/slpf_checker.sv
tb/testbench.sv
